FILE: sv/i2crm_pkg.sv
// shared types and constants for the i2c register read master
package i2crm_pkg;

  localparam int DEV_ADDR_W = 7;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 16;
  localparam int BIT_IDX_W  = 4;
  localparam int REC_CNT_W  = 4;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;

  // number of scl pulses tried while sda is held low by a target
  localparam logic [REC_CNT_W-1:0] REC_PULSES = 4'd9;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [CNT_W-1:0] STRETCH_TO_RST  = 16'd1000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_STRETCH_TO  = 1'b1
  } cfg_reg_t;

  // completion status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_STRETCH_TO  = 3'd1,
    STAT_ADDR_NACK   = 3'd2,
    STAT_DATA_NACK   = 3'd3,
    STAT_ZERO_LENGTH = 3'd4
  } status_t;

  // bus sequencer phases
  typedef enum logic [4:0] {
    ST_CHECK,
    ST_IDLE,
    ST_START_HOLD, ST_START_WAIT, ST_START_HIGH, ST_START_LOW,
    ST_RSTART_HOLD, ST_RSTART_WAIT, ST_RSTART_HIGH, ST_RSTART_LOW,
    ST_WADR_LOW, ST_WADR_WAIT, ST_WADR_HIGH,
    ST_WREG_LOW, ST_WREG_WAIT, ST_WREG_HIGH,
    ST_RADR_LOW, ST_RADR_WAIT, ST_RADR_HIGH,
    ST_READ_LOW, ST_READ_WAIT, ST_READ_HIGH,
    ST_STOP_LOW, ST_STOP_WAIT, ST_STOP_HIGH, ST_STOP_END,
    ST_REC_START, ST_REC_HIGH, ST_REC_LOW,
    ST_REC_STOP1, ST_REC_STOP2, ST_REC_STOP3
  } phase_t;

  typedef struct packed {
    logic                  command;
    logic [DEV_ADDR_W-1:0] device_address;
    logic [BYTE_W-1:0]     register_address;
    logic [BYTE_W-1:0]     byte_count;
    logic                  scl_in;
    logic                  sda_in;
  } in_item_t;

  typedef struct packed {
    logic              scl_pull_low;
    logic              sda_pull_low;
    logic              busy_res;
    logic              data_valid;
    logic [BYTE_W-1:0] read_data;
    logic              last_byte;
    logic              done_res;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] half_period_ticks;
    logic [CNT_W-1:0] stretch_timeout_ticks;
  } cfg_t;

endpackage

FILE: sv/i2crm_ifs.sv
// valid/ready channel interfaces for items, results and configuration
interface i2crm_in_if;
  import i2crm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [DEV_ADDR_W-1:0] device_address;
  logic [BYTE_W-1:0]     register_address;
  logic [BYTE_W-1:0]     byte_count;
  logic                  scl_in;
  logic                  sda_in;

  modport source (
    output valid, command, device_address, register_address, byte_count, scl_in, sda_in,
    input  ready
  );
  modport sink (
    input  valid, command, device_address, register_address, byte_count, scl_in, sda_in,
    output ready
  );
endinterface

interface i2crm_out_if;
  import i2crm_pkg::*;

  logic                valid;
  logic                ready;
  logic                scl_pull_low;
  logic                sda_pull_low;
  logic                busy_res;
  logic                data_valid;
  logic [BYTE_W-1:0]   read_data;
  logic                last_byte;
  logic                done_res;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, scl_pull_low, sda_pull_low, busy_res, data_valid, read_data, last_byte,
           done_res, status,
    input  ready
  );
  modport sink (
    input  valid, scl_pull_low, sda_pull_low, busy_res, data_valid, read_data, last_byte,
           done_res, status,
    output ready
  );
endinterface

interface i2crm_cfg_if;
  import i2crm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CNT_W-1:0]     wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

FILE: sv/i2crm_core.sv
// bus sequencer: phase state, timing counters and byte shifter, one step per item
module i2crm_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  i2crm_pkg::in_item_t  item,
  input  i2crm_pkg::cfg_t      cfg,
  output i2crm_pkg::out_item_t res
);
  import i2crm_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [CNT_W-1:0]      hcnt_r, hcnt_nxt;
  logic [CNT_W-1:0]      scnt_r, scnt_nxt;
  logic [BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [BYTE_W-1:0]     left_r, left_nxt;
  logic [BYTE_W-1:0]     shift_r, shift_nxt;
  logic [DEV_ADDR_W-1:0] dev_r, dev_nxt;
  logic [BYTE_W-1:0]     reg_r, reg_nxt;
  status_t               hstat_r, hstat_nxt;
  logic [REC_CNT_W-1:0]  recp_r, recp_nxt;
  logic                  scl_drv_r, scl_drv_nxt;
  logic                  sda_drv_r, sda_drv_nxt;

  // state as seen after the post-reset bus check
  phase_t                phase_e;
  status_t               hstat_e;
  logic [REC_CNT_W-1:0]  recp_e;
  logic                  scl_e, sda_e;

  logic [CNT_W-1:0]      hp_eff;
  logic                  half_hit, scl_to, rec_more;
  logic                  half_phase, wait_phase;
  logic [BIT_IDX_W-1:0]  bit_inc;

  // sda level driven for bit idx of a byte being sent (ack slot releases)
  function automatic logic write_bit(input logic [BYTE_W-1:0] b,
                                     input logic [BIT_IDX_W-1:0] idx);
    logic [2:0] sel;
    sel = 3'd7 - idx[2:0];
    return idx[BIT_IDX_W-1] ? 1'b0 : !b[sel];
  endfunction

  // bus check on the first step after reset
  always_comb begin
    phase_e = phase_r;
    hstat_e = hstat_r;
    recp_e  = recp_r;
    scl_e   = scl_drv_r;
    sda_e   = sda_drv_r;
    if (phase_r == ST_CHECK) begin
      if (!item.sda_in) begin
        phase_e = ST_REC_START;
        hstat_e = STAT_OK;
        recp_e  = '0;
        scl_e   = 1'b1;
        sda_e   = 1'b0;
      end else begin
        phase_e = ST_IDLE;
      end
    end
  end

  // timing events
  always_comb begin
    hp_eff   = (cfg.half_period_ticks == '0) ? CNT_W'(1) : cfg.half_period_ticks;
    half_hit = ({1'b0, hcnt_r} + (CNT_W+1)'(1)) >= {1'b0, hp_eff};
    scl_to   = !item.scl_in && (scnt_r >= cfg.stretch_timeout_ticks);
    rec_more = (recp_e < REC_PULSES) && !item.sda_in;
    bit_inc  = bit_r + BIT_IDX_W'(1);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_e;
    unique case (phase_e)
      ST_CHECK, ST_IDLE: begin
        if (item.command && item.byte_count != '0) phase_nxt = ST_START_HOLD;
      end
      ST_START_HOLD:  if (half_hit) phase_nxt = ST_START_WAIT;
      ST_START_WAIT: begin
        if (item.scl_in) phase_nxt = ST_START_HIGH;
        else if (scl_to) phase_nxt = ST_REC_START;
      end
      ST_START_HIGH:  if (half_hit) phase_nxt = ST_START_LOW;
      ST_START_LOW:   if (half_hit) phase_nxt = ST_WADR_LOW;
      ST_RSTART_HOLD: if (half_hit) phase_nxt = ST_RSTART_WAIT;
      ST_RSTART_WAIT: begin
        if (item.scl_in) phase_nxt = ST_RSTART_HIGH;
        else if (scl_to) phase_nxt = ST_REC_START;
      end
      ST_RSTART_HIGH: if (half_hit) phase_nxt = ST_RSTART_LOW;
      ST_RSTART_LOW:  if (half_hit) phase_nxt = ST_RADR_LOW;
      ST_WADR_LOW:    if (half_hit) phase_nxt = ST_WADR_WAIT;
      ST_WREG_LOW:    if (half_hit) phase_nxt = ST_WREG_WAIT;
      ST_RADR_LOW:    if (half_hit) phase_nxt = ST_RADR_WAIT;
      ST_WADR_WAIT: begin
        if (item.scl_in) phase_nxt = ST_WADR_HIGH;
        else if (scl_to) phase_nxt = ST_REC_START;
      end
      ST_WREG_WAIT: begin
        if (item.scl_in) phase_nxt = ST_WREG_HIGH;
        else if (scl_to) phase_nxt = ST_REC_START;
      end
      ST_RADR_WAIT: begin
        if (item.scl_in) phase_nxt = ST_RADR_HIGH;
        else if (scl_to) phase_nxt = ST_REC_START;
      end
      ST_WADR_HIGH: begin
        if (half_hit) begin
          if (!bit_r[BIT_IDX_W-1]) phase_nxt = ST_WADR_LOW;
          else if (item.sda_in)    phase_nxt = ST_REC_START;
          else                     phase_nxt = ST_WREG_LOW;
        end
      end
      ST_WREG_HIGH: begin
        if (half_hit) begin
          if (!bit_r[BIT_IDX_W-1]) phase_nxt = ST_WREG_LOW;
          else if (item.sda_in)    phase_nxt = ST_REC_START;
          else                     phase_nxt = ST_RSTART_HOLD;
        end
      end
      ST_RADR_HIGH: begin
        if (half_hit) begin
          if (!bit_r[BIT_IDX_W-1]) phase_nxt = ST_RADR_LOW;
          else if (item.sda_in)    phase_nxt = ST_REC_START;
          else                     phase_nxt = ST_READ_LOW;
        end
      end
      ST_READ_LOW: if (half_hit) phase_nxt = ST_READ_WAIT;
      ST_READ_WAIT: begin
        if (item.scl_in) phase_nxt = ST_READ_HIGH;
        else if (scl_to) phase_nxt = ST_REC_START;
      end
      ST_READ_HIGH: begin
        if (half_hit) begin
          if (!bit_r[BIT_IDX_W-1] || left_r > BYTE_W'(1)) phase_nxt = ST_READ_LOW;
          else                                            phase_nxt = ST_STOP_LOW;
        end
      end
      ST_STOP_LOW:  if (half_hit) phase_nxt = ST_STOP_WAIT;
      ST_STOP_WAIT: if (item.scl_in || scl_to) phase_nxt = ST_STOP_HIGH;
      ST_STOP_HIGH: if (half_hit) phase_nxt = ST_STOP_END;
      ST_STOP_END: begin
        if (half_hit) phase_nxt = (hstat_e != STAT_OK) ? ST_REC_START : ST_IDLE;
      end
      ST_REC_START, ST_REC_LOW: begin
        if (half_hit) phase_nxt = rec_more ? ST_REC_HIGH : ST_REC_STOP1;
      end
      ST_REC_HIGH:  if (half_hit) phase_nxt = ST_REC_LOW;
      ST_REC_STOP1: if (half_hit) phase_nxt = ST_REC_STOP2;
      ST_REC_STOP2: if (half_hit) phase_nxt = ST_REC_STOP3;
      ST_REC_STOP3: if (half_hit) phase_nxt = ST_IDLE;
    endcase
  end

  // wire drives, shifter, held transaction fields and result
  always_comb begin
    scl_drv_nxt = scl_e;
    sda_drv_nxt = sda_e;
    hstat_nxt   = hstat_e;
    recp_nxt    = recp_e;
    bit_nxt     = bit_r;
    left_nxt    = left_r;
    shift_nxt   = shift_r;
    dev_nxt     = dev_r;
    reg_nxt     = reg_r;
    res         = '0;
    half_phase  = 1'b1;
    wait_phase  = 1'b0;

    case (phase_e)
      ST_CHECK, ST_IDLE: begin
        half_phase  = 1'b0;
        scl_drv_nxt = 1'b0;
        sda_drv_nxt = 1'b0;
        if (item.command) begin
          if (item.byte_count == '0) begin
            res.done_res = 1'b1;
            res.status   = STAT_ZERO_LENGTH;
          end else begin
            dev_nxt   = item.device_address;
            reg_nxt   = item.register_address;
            left_nxt  = item.byte_count;
            hstat_nxt = STAT_OK;
          end
        end
      end
      // scl released: rising scl edge
      ST_START_HOLD, ST_RSTART_HOLD, ST_WADR_LOW, ST_WREG_LOW, ST_RADR_LOW, ST_READ_LOW,
      ST_STOP_LOW, ST_REC_STOP1: begin
        if (half_hit) scl_drv_nxt = 1'b0;
      end
      // released scl, wait for the wire with stretch timeout
      ST_START_WAIT, ST_RSTART_WAIT, ST_WADR_WAIT, ST_WREG_WAIT, ST_RADR_WAIT,
      ST_READ_WAIT: begin
        half_phase = 1'b0;
        wait_phase = 1'b1;
        if (!item.scl_in && scl_to) begin
          hstat_nxt   = STAT_STRETCH_TO;
          scl_drv_nxt = 1'b1;
          sda_drv_nxt = 1'b0;
          recp_nxt    = '0;
        end
      end
      ST_STOP_WAIT: begin
        half_phase = 1'b0;
        wait_phase = 1'b1;
        if (!item.scl_in && scl_to) hstat_nxt = STAT_STRETCH_TO;
      end
      // start or repeated start: sda falls while scl is high
      ST_START_HIGH, ST_RSTART_HIGH: begin
        if (half_hit) sda_drv_nxt = 1'b1;
      end
      ST_START_LOW, ST_RSTART_LOW: begin
        if (half_hit) begin
          scl_drv_nxt = 1'b1;
          shift_nxt   = {dev_r, (phase_e == ST_RSTART_LOW)};
          bit_nxt     = '0;
          sda_drv_nxt = !dev_r[DEV_ADDR_W-1];
        end
      end
      // end of a sent bit or of the ack slot
      ST_WADR_HIGH, ST_WREG_HIGH, ST_RADR_HIGH: begin
        if (half_hit) begin
          scl_drv_nxt = 1'b1;
          if (!bit_r[BIT_IDX_W-1]) begin
            bit_nxt     = bit_inc;
            sda_drv_nxt = write_bit(shift_r, bit_inc);
          end else if (item.sda_in) begin
            hstat_nxt   = (phase_e == ST_WADR_HIGH) ? STAT_ADDR_NACK : STAT_DATA_NACK;
            sda_drv_nxt = 1'b0;
            recp_nxt    = '0;
          end else if (phase_e == ST_WADR_HIGH) begin
            shift_nxt   = reg_r;
            bit_nxt     = '0;
            sda_drv_nxt = !reg_r[BYTE_W-1];
          end else if (phase_e == ST_WREG_HIGH) begin
            sda_drv_nxt = 1'b0;
          end else begin
            bit_nxt     = '0;
            shift_nxt   = '0;
            sda_drv_nxt = 1'b0;
          end
        end
      end
      // sample a received bit, or finish the ack/nack slot
      ST_READ_HIGH: begin
        if (half_hit) begin
          scl_drv_nxt = 1'b1;
          if (!bit_r[BIT_IDX_W-1]) begin
            shift_nxt = {shift_r[BYTE_W-2:0], item.sda_in};
            bit_nxt   = bit_inc;
            if (bit_inc[BIT_IDX_W-1]) sda_drv_nxt = left_r > BYTE_W'(1);
          end else begin
            res.data_valid = 1'b1;
            res.read_data  = shift_r;
            res.last_byte  = left_r <= BYTE_W'(1);
            if (left_r > BYTE_W'(1)) begin
              sda_drv_nxt = 1'b0;
              left_nxt    = left_r - BYTE_W'(1);
              bit_nxt     = '0;
              shift_nxt   = '0;
            end else begin
              left_nxt    = '0;
              sda_drv_nxt = 1'b1;
            end
          end
        end
      end
      // stop: sda rises while scl is high
      ST_STOP_HIGH, ST_REC_STOP2: begin
        if (half_hit) sda_drv_nxt = 1'b0;
      end
      ST_STOP_END: begin
        if (half_hit) begin
          if (hstat_e != STAT_OK) begin
            scl_drv_nxt = 1'b1;
            sda_drv_nxt = 1'b0;
            recp_nxt    = '0;
          end else begin
            res.done_res = 1'b1;
            res.status   = STAT_OK;
          end
        end
      end
      // recovery pulses while sda is held low
      ST_REC_START, ST_REC_LOW: begin
        if (half_hit) begin
          if (rec_more) begin
            scl_drv_nxt = 1'b0;
            recp_nxt    = recp_e + REC_CNT_W'(1);
          end else begin
            sda_drv_nxt = 1'b1;
          end
        end
      end
      ST_REC_HIGH: begin
        if (half_hit) scl_drv_nxt = 1'b1;
      end
      ST_REC_STOP3: begin
        if (half_hit && hstat_e != STAT_OK) begin
          res.done_res = 1'b1;
          res.status   = hstat_e;
        end
      end
      default: begin
        half_phase = 1'b0;
      end
    endcase

    res.scl_pull_low = scl_drv_nxt;
    res.sda_pull_low = sda_drv_nxt;
    res.busy_res     = phase_nxt != ST_IDLE;
  end

  // timing counters restart on every phase change
  always_comb begin
    hcnt_nxt = hcnt_r;
    scnt_nxt = scnt_r;
    if (phase_nxt != phase_e) begin
      hcnt_nxt = '0;
      scnt_nxt = '0;
    end else begin
      if (half_phase) hcnt_nxt = hcnt_r + CNT_W'(1);
      if (wait_phase) scnt_nxt = scnt_r + CNT_W'(1);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ST_CHECK;
      hcnt_r    <= '0;
      scnt_r    <= '0;
      bit_r     <= '0;
      left_r    <= '0;
      shift_r   <= '0;
      dev_r     <= '0;
      reg_r     <= '0;
      hstat_r   <= STAT_OK;
      recp_r    <= '0;
      scl_drv_r <= 1'b0;
      sda_drv_r <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hcnt_r    <= hcnt_nxt;
      scnt_r    <= scnt_nxt;
      bit_r     <= bit_nxt;
      left_r    <= left_nxt;
      shift_r   <= shift_nxt;
      dev_r     <= dev_nxt;
      reg_r     <= reg_nxt;
      hstat_r   <= hstat_nxt;
      recp_r    <= recp_nxt;
      scl_drv_r <= scl_drv_nxt;
      sda_drv_r <= sda_drv_nxt;
    end
  end

endmodule

FILE: sv/i2c_register_read_master.sv
// i2c register read master: tick channel in, one result per tick out
// an input transfer lands in the input register, and its result then moves into the output register
// throughput: one item per cycle while the result side is ready, set by the single-step sequencer between the registers
// the input and output registers each hold one transfer while the far side stalls
// reset (synchronous, rst_n low): bus check on the first tick, registers back to
// half period 5 and stretch timeout 1000, both channel registers emptied
module i2c_register_read_master (
  input  logic        clk,
  input  logic        rst_n,
  i2crm_in_if.sink    in_chan,
  i2crm_out_if.source out_chan,
  i2crm_cfg_if.sink   cfg_chan
);
  import i2crm_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  cfg_t      cfg_r;
  out_item_t step_res;
  logic      out_free;
  logic      step;

  // handshake control
  assign out_free       = !out_valid_r || out_chan.ready;
  assign step           = in_valid_r && out_free;
  assign in_chan.ready  = !in_valid_r || step;
  assign cfg_chan.ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.command          <= in_chan.command;
      in_item_r.device_address   <= in_chan.device_address;
      in_item_r.register_address <= in_chan.register_address;
      in_item_r.byte_count       <= in_chan.byte_count;
      in_item_r.scl_in           <= in_chan.scl_in;
      in_item_r.sda_in           <= in_chan.sda_in;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks     <= HALF_PERIOD_RST;
      cfg_r.stretch_timeout_ticks <= STRETCH_TO_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_reg_t'(cfg_chan.reg_index))
        CFG_HALF_PERIOD: cfg_r.half_period_ticks     <= cfg_chan.wr_data;
        CFG_STRETCH_TO:  cfg_r.stretch_timeout_ticks <= cfg_chan.wr_data;
      endcase
    end
  end

  // bus sequencer
  i2crm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= step_res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.scl_pull_low = out_item_r.scl_pull_low;
  assign out_chan.sda_pull_low = out_item_r.sda_pull_low;
  assign out_chan.busy_res     = out_item_r.busy_res;
  assign out_chan.data_valid   = out_item_r.data_valid;
  assign out_chan.read_data    = out_item_r.read_data;
  assign out_chan.last_byte    = out_item_r.last_byte;
  assign out_chan.done_res     = out_item_r.done_res;
  assign out_chan.status       = out_item_r.status;

  // a stepped item always lands in the output register
  assert property (@(posedge clk) disable iff (!rst_n) step |=> out_valid_r)
    else $error("stepped item did not reach the output register");

  // a received byte and a completion never share a result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.data_valid && out_item_r.done_res))
    else $error("data and completion in the same result");

  // status only carries meaning on completion
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.done_res) |-> (out_item_r.status == STAT_OK))
    else $error("status set without completion");

  // last byte flag only comes with a received byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last_byte) |-> out_item_r.data_valid)
    else $error("last byte flagged without data");

endmodule

FILE: tb/sv/i2crm_checker.sv
// result checker for the i2c register read master: predicts every tick and compares results
module i2crm_checker
  import i2crm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  i2crm_in_if  in_mon,
  i2crm_out_if out_mon,
  i2crm_cfg_if cfg_mon,
  output int   fail_count,
  output int   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // outcome of one look at a released scl line
  typedef enum logic [1:0] {
    SCL_STRETCHED,
    SCL_RELEASED,
    SCL_TIMED_OUT
  } scl_poll_t;

  // configuration as last written
  logic [CNT_W-1:0] half_ticks;
  logic [CNT_W-1:0] stretch_limit;

  // predicted sequencer state
  phase_t                ph;
  logic [CNT_W-1:0]      half_cnt;
  logic [CNT_W-1:0]      stretch_cnt;
  logic [BIT_IDX_W-1:0]  bit_idx;
  logic [BYTE_W-1:0]     bytes_left;
  logic [BYTE_W-1:0]     shreg;
  logic [DEV_ADDR_W-1:0] dev_held;
  logic [BYTE_W-1:0]     reg_held;
  status_t               status_held;
  logic [REC_CNT_W-1:0]  pulses;
  logic                  scl_low;
  logic                  sda_low;

  out_item_t expected_results[$];
  int        mismatch_total;

  function automatic void reset_predictor();
    half_ticks    = HALF_PERIOD_RST;
    stretch_limit = STRETCH_TO_RST;
    ph            = ST_CHECK;
    half_cnt      = '0;
    stretch_cnt   = '0;
    bit_idx       = '0;
    bytes_left    = '0;
    shreg         = '0;
    dev_held      = '0;
    reg_held      = '0;
    status_held   = STAT_OK;
    pulses        = '0;
    scl_low       = 1'b0;
    sda_low       = 1'b0;
  endfunction

  function automatic void enter(phase_t nxt);
    ph          = nxt;
    half_cnt    = '0;
    stretch_cnt = '0;
  endfunction

  // one tick of the current half period; a zero setting counts as one tick
  function automatic bit half_elapsed();
    logic [CNT_W-1:0] span;
    span = (half_ticks == '0) ? 16'd1 : half_ticks;
    half_cnt = half_cnt + 16'd1;
    if (half_cnt >= span) begin
      half_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic scl_poll_t scl_poll(logic scl);
    if (scl) return SCL_RELEASED;
    if (stretch_cnt >= stretch_limit) return SCL_TIMED_OUT;
    stretch_cnt = stretch_cnt + 16'd1;
    return SCL_STRETCHED;
  endfunction

  // sda for the current outgoing bit, released for the ack slot
  function automatic void drive_tx_bit();
    if (bit_idx < 4'd8) sda_low = ~shreg[3'd7 - bit_idx[2:0]];
    else sda_low = 1'b0;
  endfunction

  function automatic void load_tx(phase_t first, logic [BYTE_W-1:0] b);
    shreg   = b;
    bit_idx = '0;
    drive_tx_bit();
    enter(first);
  endfunction

  function automatic void start_recovery(status_t code);
    status_held = code;
    scl_low     = 1'b1;
    sda_low     = 1'b0;
    pulses      = '0;
    enter(ST_REC_START);
  endfunction

  // another scl pulse while a target holds sda, otherwise finish with a stop
  function automatic void recovery_probe(logic sda);
    if (pulses < REC_PULSES && !sda) begin
      scl_low = 1'b0;
      pulses  = pulses + 4'd1;
      enter(ST_REC_HIGH);
    end else begin
      sda_low = 1'b1;
      enter(ST_REC_STOP1);
    end
  endfunction

  function automatic out_item_t predict_tick(in_item_t it);
    out_item_t r;
    scl_poll_t w;
    r = '0;
    // bus check on the first tick after reset
    if (ph == ST_CHECK) begin
      if (!it.sda_in) start_recovery(STAT_OK);
      else enter(ST_IDLE);
    end
    case (ph)
      ST_IDLE: begin
        scl_low = 1'b0;
        sda_low = 1'b0;
        if (it.command) begin
          if (it.byte_count == '0) begin
            r.done_res = 1'b1;
            r.status   = STAT_ZERO_LENGTH;
          end else begin
            dev_held    = it.device_address;
            reg_held    = it.register_address;
            bytes_left  = it.byte_count;
            status_held = STAT_OK;
            enter(ST_START_HOLD);
          end
        end
      end
      ST_START_HOLD, ST_RSTART_HOLD, ST_WADR_LOW, ST_WREG_LOW, ST_RADR_LOW,
      ST_READ_LOW: begin
        if (half_elapsed()) begin
          scl_low = 1'b0;
          enter(phase_t'(ph + 1));
        end
      end
      ST_START_WAIT, ST_RSTART_WAIT, ST_WADR_WAIT, ST_WREG_WAIT, ST_RADR_WAIT,
      ST_READ_WAIT: begin
        w = scl_poll(it.scl_in);
        if (w == SCL_RELEASED) enter(phase_t'(ph + 1));
        else if (w == SCL_TIMED_OUT) start_recovery(STAT_STRETCH_TO);
      end
      ST_START_HIGH, ST_RSTART_HIGH: begin
        if (half_elapsed()) begin
          sda_low = 1'b1;
          enter(phase_t'(ph + 1));
        end
      end
      ST_START_LOW: begin
        if (half_elapsed()) begin
          scl_low = 1'b1;
          load_tx(ST_WADR_LOW, {dev_held, 1'b0});
        end
      end
      ST_RSTART_LOW: begin
        if (half_elapsed()) begin
          scl_low = 1'b1;
          load_tx(ST_RADR_LOW, {dev_held, 1'b1});
        end
      end
      ST_WADR_HIGH, ST_WREG_HIGH, ST_RADR_HIGH: begin
        if (half_elapsed()) begin
          scl_low = 1'b1;
          if (bit_idx < 4'd8) begin
            bit_idx = bit_idx + 4'd1;
            drive_tx_bit();
            enter(phase_t'(ph - 2));
          end else if (it.sda_in) begin
            start_recovery(ph == ST_WADR_HIGH ? STAT_ADDR_NACK : STAT_DATA_NACK);
          end else begin
            case (ph)
              ST_WADR_HIGH: load_tx(ST_WREG_LOW, reg_held);
              ST_WREG_HIGH: begin
                sda_low = 1'b0;
                enter(ST_RSTART_HOLD);
              end
              default: begin
                bit_idx = '0;
                shreg   = '0;
                sda_low = 1'b0;
                enter(ST_READ_LOW);
              end
            endcase
          end
        end
      end
      ST_READ_HIGH: begin
        if (half_elapsed()) begin
          scl_low = 1'b1;
          if (bit_idx < 4'd8) begin
            shreg   = {shreg[6:0], it.sda_in};
            bit_idx = bit_idx + 4'd1;
            // ack every byte but the last
            if (bit_idx == 4'd8) sda_low = bytes_left > 8'd1;
            enter(ST_READ_LOW);
          end else begin
            sda_low     = 1'b0;
            r.data_valid = 1'b1;
            r.read_data  = shreg;
            r.last_byte  = bytes_left <= 8'd1;
            if (bytes_left > 8'd1) begin
              bytes_left = bytes_left - 8'd1;
              bit_idx    = '0;
              shreg      = '0;
              enter(ST_READ_LOW);
            end else begin
              bytes_left = '0;
              sda_low    = 1'b1;
              enter(ST_STOP_LOW);
            end
          end
        end
      end
      ST_STOP_LOW: begin
        if (half_elapsed()) begin
          scl_low = 1'b0;
          enter(ST_STOP_WAIT);
        end
      end
      ST_STOP_WAIT: begin
        // a timeout here still completes the stop first
        w = scl_poll(it.scl_in);
        if (w == SCL_TIMED_OUT) status_held = STAT_STRETCH_TO;
        if (w != SCL_STRETCHED) enter(ST_STOP_HIGH);
      end
      ST_STOP_HIGH: begin
        if (half_elapsed()) begin
          sda_low = 1'b0;
          enter(ST_STOP_END);
        end
      end
      ST_STOP_END: begin
        if (half_elapsed()) begin
          if (status_held != STAT_OK) begin
            start_recovery(status_held);
          end else begin
            r.done_res = 1'b1;
            r.status   = STAT_OK;
            enter(ST_IDLE);
          end
        end
      end
      ST_REC_START, ST_REC_LOW: begin
        if (half_elapsed()) recovery_probe(it.sda_in);
      end
      ST_REC_HIGH: begin
        if (half_elapsed()) begin
          scl_low = 1'b1;
          enter(ST_REC_LOW);
        end
      end
      ST_REC_STOP1: begin
        if (half_elapsed()) begin
          scl_low = 1'b0;
          enter(ST_REC_STOP2);
        end
      end
      ST_REC_STOP2: begin
        if (half_elapsed()) begin
          sda_low = 1'b0;
          enter(ST_REC_STOP3);
        end
      end
      ST_REC_STOP3: begin
        // recovery after reset ends silently
        if (half_elapsed()) begin
          if (status_held != STAT_OK) begin
            r.done_res = 1'b1;
            r.status   = status_held;
          end
          enter(ST_IDLE);
        end
      end
      default: enter(ST_IDLE);
    endcase
    r.scl_pull_low = scl_low;
    r.sda_pull_low = sda_low;
    r.busy_res     = ph != ST_IDLE;
    return r;
  endfunction

  function automatic string result_text(out_item_t r);
    return $sformatf("scl %0b sda %0b busy %0b dv %0b data %02h last %0b done %0b status %0d",
                     r.scl_pull_low, r.sda_pull_low, r.busy_res, r.data_valid, r.read_data,
                     r.last_byte, r.done_res, r.status);
  endfunction

  initial begin
    reset_predictor();
    mismatch_total = 0;
  end

  // prediction on each input transfer, comparison on each result transfer
  always @(posedge clk) begin
    in_item_t  tick;
    out_item_t seen;
    out_item_t want;
    if (!rst_n) begin
      reset_predictor();
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.reg_index))
          CFG_HALF_PERIOD: half_ticks    = cfg_mon.wr_data;
          CFG_STRETCH_TO:  stretch_limit = cfg_mon.wr_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        tick.command          = in_mon.command;
        tick.device_address   = in_mon.device_address;
        tick.register_address = in_mon.register_address;
        tick.byte_count       = in_mon.byte_count;
        tick.scl_in           = in_mon.scl_in;
        tick.sda_in           = in_mon.sda_in;
        expected_results.push_back(predict_tick(tick));
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.scl_pull_low = out_mon.scl_pull_low;
        seen.sda_pull_low = out_mon.sda_pull_low;
        seen.busy_res     = out_mon.busy_res;
        seen.data_valid   = out_mon.data_valid;
        seen.read_data    = out_mon.read_data;
        seen.last_byte    = out_mon.last_byte;
        seen.done_res     = out_mon.done_res;
        seen.status       = status_t'(out_mon.status);
        if (expected_results.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t unexpected result transfer: %s", $realtime, result_text(seen));
          mismatch_total++;
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            if (mismatch_total < 10)
              $display("%0t result mismatch\n  expected %s\n  actual   %s", $realtime,
                       result_text(want), result_text(seen));
            mismatch_total++;
          end
        end
      end
    end
    fail_count      <= mismatch_total;
    pending_results <= expected_results.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// top of the i2c register read master testbench: clock, reset, bus stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2crm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_TICKS = 30;
  localparam int NEVER       = 1 << 30;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          steady;
  bit          bus_busy;
  int          cycle_count;
  int          ticks_sent;
  int          fail_count;
  int          pending_results;
  logic [15:0] cur_half;

  i2crm_in_if  in_chan();
  i2crm_out_if out_chan();
  i2crm_cfg_if cfg_chan();

  i2c_register_read_master u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  i2crm_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_mon         (cfg_chan),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #6 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    out_chan.ready <= steady || ($urandom_range(99) >= 26);
  end

  // bus activity as seen in the latest result transfer
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) bus_busy <= out_chan.busy_res;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("i2c_register_read_master verification failed");
      $finish;
    end
  end

  // one tick transfer, with random idle cycles ahead of it
  task automatic send_tick(input in_item_t it);
    if (!steady && $urandom_range(99) < 26) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 26);
    end
    in_chan.valid            <= 1'b1;
    in_chan.command          <= it.command;
    in_chan.device_address   <= it.device_address;
    in_chan.register_address <= it.register_address;
    in_chan.byte_count       <= it.byte_count;
    in_chan.scl_in           <= it.scl_in;
    in_chan.sda_in           <= it.sda_in;
    do @(posedge clk); while (!in_chan.ready);
    ticks_sent++;
  endtask

  // hold off until every predicted result has been taken
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] data);
    wait_drained();
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.wr_data   <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    if (idx == CFG_HALF_PERIOD) cur_half = data;
  endtask

  // one read request followed by bus ticks until the master goes quiet;
  // sda reads low for the first sda_low ticks, then high with weight p_sda1/16,
  // scl reads low with weight p_scl0/16 and always from tick scl_low_from on
  task automatic run_read(input logic [6:0] dev, input logic [7:0] regad,
                          input logic [7:0] cnt, input int sda_low, input int p_sda1,
                          input int p_scl0, input int scl_low_from, input int max_ticks,
                          input bit noisy);
    in_item_t it;
    int       k;
    k = 0;
    while ((k < 12 || bus_busy) && k < max_ticks) begin
      if (k == 0) it.command = 1'b1;
      else if (k <= 3 && cnt != 0) it.command = 1'($urandom_range(1));
      else it.command = noisy && $urandom_range(63) == 0;
      it.device_address   = (k == 0) ? dev : 7'($urandom_range(127));
      it.register_address = (k == 0) ? regad : 8'($urandom_range(255));
      it.byte_count       = (k == 0) ? cnt : 8'($urandom_range(255));
      it.scl_in = (k >= scl_low_from) ? 1'b0 : ($urandom_range(15) >= p_scl0);
      it.sda_in = (k < sda_low) ? 1'b0 : ($urandom_range(15) < p_sda1);
      send_tick(it);
      k++;
    end
  endtask

  initial begin
    int          half_set[6];
    int          stretch_set[6];
    int          span;
    int          first;
    int          sda_low;
    int          p_sda1;
    int          p_scl0;
    logic [7:0]  cnt;
    half_set    = '{0, 1, 2, 1, 3, 0};
    stretch_set = '{65535, 2, 0, 1000, 7, 30};
    rst_n                    <= 1'b0;
    steady                    = 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.command          <= 1'b0;
    in_chan.device_address   <= '0;
    in_chan.register_address <= '0;
    in_chan.byte_count       <= '0;
    in_chan.scl_in           <= 1'b1;
    in_chan.sda_in           <= 1'b1;
    cfg_chan.valid           <= 1'b0;
    cfg_chan.reg_index       <= CFG_HALF_PERIOD;
    cfg_chan.wr_data         <= '0;
    cur_half                  = HALF_PERIOD_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // sda held low at the first tick: full recovery, the command is ignored
    run_read(7'h00, 8'h00, 8'd1, NEVER, 0, 0, NEVER, 400, 1'b0);
    cfg_write(CFG_HALF_PERIOD, 16'd1);
    cfg_write(CFG_STRETCH_TO, 16'd4);
    // zero length request
    run_read(7'h7F, 8'hFF, 8'd0, 0, 0, 0, NEVER, 40, 1'b0);
    // clean reads: random bytes, then an all-ones byte
    run_read(7'h7F, 8'h00, 8'd2, 90, 8, 0, NEVER, 400, 1'b0);
    run_read(7'h00, 8'hFF, 8'd1, 90, 16, 0, NEVER, 400, 1'b0);
    // address nack, register nack, read address nack
    run_read(7'h55, 8'hAA, 8'd1, 0, 16, 0, NEVER, 400, 1'b0);
    run_read(7'h2A, 8'h55, 8'd1, 40, 16, 0, NEVER, 400, 1'b0);
    run_read(7'h33, 8'hCC, 8'd1, 70, 16, 0, NEVER, 400, 1'b0);
    // scl held low from the start: stretch timeout with recovery pulses
    run_read(7'h11, 8'h22, 8'd1, NEVER, 0, 0, 0, 400, 1'b0);
    cfg_write(CFG_STRETCH_TO, 16'd0);
    // scl stuck low at the stop condition
    run_read(7'h4C, 8'h13, 8'd1, 90, 8, 0, 118, 400, 1'b0);
    // longest read cut short by a timeout after some bytes
    run_read(7'h6B, 8'hE7, 8'd255, 90, 8, 0, 150, 400, 1'b0);

    // longest half period, briefly
    cfg_write(CFG_HALF_PERIOD, 16'hFFFF);
    run_read(7'h01, 8'h80, 8'd3, 0, 2, 3, NEVER, 60, 1'b1);

    // random traffic over several settings
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_HALF_PERIOD, 16'(half_set[ph]));
      cfg_write(CFG_STRETCH_TO, 16'(stretch_set[ph]));
      steady = (ph == 3);
      span   = (cur_half == 0) ? 1 : int'(cur_half);
      first  = ticks_sent;
      while (ticks_sent - first < PHASE_TICKS) begin
        case ($urandom_range(15))
          0:                 cnt = 8'd0;
          13, 14:            cnt = 8'($urandom_range(12, 4));
          15:                cnt = 8'($urandom_range(255, 13));
          default:           cnt = 8'($urandom_range(3, 1));
        endcase
        sda_low = ($urandom_range(3) == 0) ? 0 : $urandom_range(32 * (2 * span + 1));
        case ($urandom_range(3))
          0:       p_sda1 = 0;
          1:       p_sda1 = 2;
          2:       p_sda1 = 8;
          default: p_sda1 = 16;
        endcase
        case ($urandom_range(3))
          0, 1:    p_scl0 = 0;
          2:       p_scl0 = 3;
          default: p_scl0 = 8;
        endcase
        run_read(7'($urandom_range(127)), 8'($urandom_range(255)), cnt, sda_low, p_sda1,
                 p_scl0, NEVER, 400, 1'b1);
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("i2c_register_read_master verification clean");
    end else begin
      $display("i2c_register_read_master verification failed");
    end
    $finish;
  end

endmodule
